// ----- hw/rtl/word_aligned_chunk_dispatcher_macros.svh -----
// Assertion macros for the chunk dispatcher RTL (used by wacd_ctrl).
// Depends on nothing; the using module provides aclk and aresetn.
`ifndef WORD_ALIGNED_CHUNK_DISPATCHER_MACROS_SVH
`define WORD_ALIGNED_CHUNK_DISPATCHER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WACD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define WACD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/wacd_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
// for the word-aligned chunk dispatcher. No dependencies.
package wacd_pkg;

    localparam int MAX_WORD    = 32;
    localparam int MAX_WORKERS = 16;

    localparam int WORD_AW  = $clog2(MAX_WORD);
    localparam int WORD_LW  = $clog2(MAX_WORD + 1);
    localparam int PTR_W    = $clog2(MAX_WORKERS);
    localparam int WORKER_W = 5;
    localparam int FILL_W   = 11;
    localparam int KIND_W   = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHUNK_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END_NOTICE = 2'd2;

    // input commands
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // delimiters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // config register index (paddr[2])
    localparam logic CFG_IDX_WORKERS = 1'b0;
    localparam logic CFG_IDX_LIMIT   = 1'b1;

    localparam logic [WORKER_W-1:0] WORKERS_RESET = 5'd1;
    localparam logic [FILL_W-1:0]   LIMIT_RESET   = 11'd1024;

    typedef struct packed {
        logic                accept;
        logic                emit;
        logic [KIND_W-1:0]   kind;
        logic                last;
        logic [WORKER_W-1:0] notice_worker;
        logic                advance_ptr;
        logic                add_fill;
        logic                clear_word;
        logic                clear_all;
        logic                rd_en;
        logic [WORD_AW-1:0]  rd_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic                in_end;
        logic                in_delim;
        logic                need_flush;
        logic [WORD_LW-1:0]  word_len;
        logic                out_free;
        logic [WORKER_W-1:0] eff_workers;
    } dp_status_t;

endpackage

// ----- hw/rtl/wacd_datapath.sv -----
// Datapath: word buffer memory, word/chunk/worker state and the output register.
// Depends on wacd_pkg; driven by wacd_ctrl through dp_cmd_t.
module wacd_datapath import wacd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_cmd,
    input  logic [7:0]          s_data_byte,
    input  logic [WORKER_W-1:0] cfg_worker_count,
    input  logic [FILL_W-1:0]   cfg_chunk_limit,
    input  dp_cmd_t             dp_cmd,
    output dp_status_t          dp_status,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [KIND_W-1:0]   m_kind,
    output logic [WORKER_W-1:0] m_worker,
    output logic [7:0]          m_out_byte,
    output logic                m_last,
    output logic                m_truncated
);

    logic [7:0]          word_mem [MAX_WORD];
    logic [7:0]          rd_data_reg;

    logic [WORD_LW-1:0]  word_len_reg, word_len_next;
    logic                ovf_reg, ovf_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                m_valid_reg, m_valid_next;

    logic [KIND_W-1:0]   kind_reg;
    logic [WORKER_W-1:0] worker_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                trunc_reg;

    logic                is_delim;
    logic                in_end;
    logic                store_en;
    logic                ovf_set;
    logic [WORD_LW-1:0]  len_plus;
    logic [WORKER_W-1:0] eff_workers;
    logic [PTR_W-1:0]    eff_ptr;
    logic [WORKER_W-1:0] ptr_inc;
    logic [WORKER_W-1:0] cur_worker;
    logic [FILL_W:0]     fill_sum;
    logic                out_free;

    assign in_end   = (s_cmd == CMD_END);
    assign is_delim = (s_data_byte == CH_SPACE) || (s_data_byte == CH_NL) ||
                      (s_data_byte == CH_TAB) || (s_data_byte == CH_NUL);
    assign len_plus = word_len_reg + WORD_LW'(1);

    // word collection on an accepted text byte
    always_comb begin
        store_en = 1'b0;
        ovf_set  = 1'b0;
        if (dp_cmd.accept && !in_end) begin
            if (is_delim) begin
                store_en = (s_data_byte != CH_NUL) && (word_len_reg < WORD_LW'(MAX_WORD));
            end else if (len_plus < WORD_LW'(MAX_WORD)) begin
                store_en = 1'b1;
            end else begin
                ovf_set = 1'b1;
            end
        end
    end

    // worker count clamped to 1..MAX_WORKERS; stale pointer restarts at 0
    always_comb begin
        if (cfg_worker_count == '0) begin
            eff_workers = WORKER_W'(1);
        end else if (cfg_worker_count > WORKER_W'(MAX_WORKERS)) begin
            eff_workers = WORKER_W'(MAX_WORKERS);
        end else begin
            eff_workers = cfg_worker_count;
        end
    end

    assign eff_ptr    = (WORKER_W'(ptr_reg) >= eff_workers) ? '0 : ptr_reg;
    assign ptr_inc    = WORKER_W'(eff_ptr) + WORKER_W'(1);
    assign cur_worker = ptr_inc;
    assign fill_sum   = (FILL_W + 1)'(fill_reg) + (FILL_W + 1)'(word_len_reg);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        word_len_next = word_len_reg;
        ovf_next      = ovf_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        if (dp_cmd.clear_all) begin
            word_len_next = '0;
            ovf_next      = 1'b0;
            fill_next     = '0;
            ptr_next      = '0;
        end else begin
            if (dp_cmd.clear_word) begin
                word_len_next = '0;
                ovf_next      = 1'b0;
            end else begin
                if (store_en) word_len_next = len_plus;
                if (ovf_set)  ovf_next = 1'b1;
            end
            if (dp_cmd.advance_ptr) begin
                fill_next = '0;
                ptr_next  = (ptr_inc >= eff_workers) ? '0 : ptr_inc[PTR_W-1:0];
            end else begin
                if (dp_cmd.add_fill) fill_next = fill_sum[FILL_W-1:0];
                // a stale pointer settles to 0 once it has been used
                if (dp_cmd.emit) ptr_next = eff_ptr;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (dp_cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg <= '0;
            ovf_reg      <= 1'b0;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            word_len_reg <= word_len_next;
            ovf_reg      <= ovf_next;
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            word_mem[word_len_reg[WORD_AW-1:0]] <= s_data_byte;
        end
        if (dp_cmd.rd_en) begin
            rd_data_reg <= word_mem[dp_cmd.rd_addr];
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (dp_cmd.emit) begin
            kind_reg   <= dp_cmd.kind;
            worker_reg <= (dp_cmd.kind == KIND_END_NOTICE) ? dp_cmd.notice_worker
                                                           : cur_worker;
            byte_reg   <= (dp_cmd.kind == KIND_DATA) ? rd_data_reg : 8'h00;
            trunc_reg  <= (dp_cmd.kind == KIND_DATA) && ovf_reg;
            last_reg   <= dp_cmd.last;
        end
    end

    always_comb begin
        dp_status.in_end      = in_end;
        dp_status.in_delim    = is_delim;
        dp_status.need_flush  = fill_sum > (FILL_W + 1)'(cfg_chunk_limit);
        dp_status.word_len    = word_len_reg;
        dp_status.out_free    = out_free;
        dp_status.eff_workers = eff_workers;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = kind_reg;
    assign m_worker    = worker_reg;
    assign m_out_byte  = byte_reg;
    assign m_last      = last_reg;
    assign m_truncated = trunc_reg;

endmodule

// ----- hw/rtl/wacd_ctrl.sv -----
// Controller FSM: sequences word commit, chunk flush, byte replay and end notices.
// Depends on wacd_pkg and word_aligned_chunk_dispatcher_macros.svh.
`include "word_aligned_chunk_dispatcher_macros.svh"

module wacd_ctrl import wacd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_COMMIT = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_DATA   = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_ENDCH  = 3'd5;
    localparam logic [2:0] ST_NOTICE = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic                end_reg, end_next;
    logic [WORD_LW-1:0]  idx_reg, idx_next;
    logic [WORKER_W-1:0] ncnt_reg, ncnt_next;

    logic [WORD_LW-1:0]  idx_plus;
    logic                data_done;
    logic                notice_done;

    assign s_ready     = (state_reg == ST_IDLE);
    assign idx_plus    = idx_reg + WORD_LW'(1);
    assign data_done   = (idx_plus == dp_status.word_len);
    assign notice_done = (ncnt_reg == dp_status.eff_workers);

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        idx_next   = idx_reg;
        ncnt_next  = ncnt_reg;
        dp_cmd     = '0;
        dp_cmd.accept = s_valid && s_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (dp_cmd.accept) begin
                    end_next = dp_status.in_end;
                    if (dp_status.in_end || dp_status.in_delim) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                // prefetch first word byte
                dp_cmd.rd_en   = 1'b1;
                dp_cmd.rd_addr = '0;
                idx_next       = '0;
                if (dp_status.need_flush) begin
                    state_next = ST_FLUSH;
                end else if (dp_status.word_len != '0) begin
                    state_next = ST_DATA;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FLUSH: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit        = 1'b1;
                    dp_cmd.kind        = KIND_CHUNK_END;
                    dp_cmd.last        = !end_reg && (dp_status.word_len == '0);
                    dp_cmd.advance_ptr = 1'b1;
                    state_next = (dp_status.word_len != '0) ? ST_DATA : ST_FIN;
                end
            end
            ST_DATA: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit    = 1'b1;
                    dp_cmd.kind    = KIND_DATA;
                    dp_cmd.last    = !end_reg && data_done;
                    dp_cmd.rd_en   = 1'b1;
                    dp_cmd.rd_addr = idx_plus[WORD_AW-1:0];
                    idx_next       = idx_plus;
                    if (data_done) state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                dp_cmd.add_fill   = 1'b1;
                dp_cmd.clear_word = 1'b1;
                state_next = end_reg ? ST_ENDCH : ST_IDLE;
            end
            ST_ENDCH: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit        = 1'b1;
                    dp_cmd.kind        = KIND_CHUNK_END;
                    dp_cmd.advance_ptr = 1'b1;
                    ncnt_next  = WORKER_W'(1);
                    state_next = ST_NOTICE;
                end
            end
            ST_NOTICE: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit          = 1'b1;
                    dp_cmd.kind          = KIND_END_NOTICE;
                    dp_cmd.notice_worker = ncnt_reg;
                    dp_cmd.last          = notice_done;
                    if (notice_done) begin
                        dp_cmd.clear_all = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        ncnt_next = ncnt_reg + WORKER_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
            idx_reg   <= '0;
            ncnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
            idx_reg   <= idx_next;
            ncnt_reg  <= ncnt_next;
        end
    end

    `WACD_ASSERT_SAME(a_emit_free, dp_cmd.emit, dp_status.out_free, "emit while output busy")
    `WACD_ASSERT_SAME(a_data_idx, state_reg == ST_DATA, idx_reg < dp_status.word_len, "replay index past word")
    `WACD_ASSERT_SAME(a_notice_range, state_reg == ST_NOTICE, (ncnt_reg != '0) && (ncnt_reg <= dp_status.eff_workers), "notice worker out of range")
    `WACD_ASSERT_NEXT(a_notice_done, (state_reg == ST_NOTICE) && dp_cmd.emit && dp_cmd.last, state_reg == ST_IDLE, "no return to idle after last notice")

endmodule

// ----- hw/rtl/word_aligned_chunk_dispatcher.sv -----
// Top level of the word-aligned chunk dispatcher: config registers and wiring.
// Depends on wacd_pkg, wacd_ctrl and wacd_datapath.
//
//   channel   handshake          payload
//   s_*       s_valid/s_ready    s_cmd, s_data_byte
//   m_*       m_valid/m_ready    m_kind, m_worker, m_out_byte, m_last, m_truncated
//   apb       psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// Plain text bytes are taken one per cycle. A delimiter commits the word: a chunk end
// first if the chunk would overflow, then one replay read of the word buffer per byte.
// End of input also closes the chunk and sends an end notice per active worker, one
// result per cycle. A stalled m_ready holds the sequencer; the input waits while a word
// is committed or the stream is closed.
// Reset is synchronous (aresetn low); all stream state clears, registers go to defaults.
module word_aligned_chunk_dispatcher import wacd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_kind,
    output logic [WORKER_W-1:0] m_worker,
    output logic [7:0]          m_out_byte,
    output logic                m_last,
    output logic                m_truncated,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [WORKER_W-1:0] worker_count_reg;
    logic [FILL_W-1:0]   chunk_limit_reg;
    logic                cfg_wr;
    dp_cmd_t             dp_cmd;
    dp_status_t          dp_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_count_reg <= WORKERS_RESET;
            chunk_limit_reg  <= LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_IDX_WORKERS: worker_count_reg <= pwdata[WORKER_W-1:0];
                CFG_IDX_LIMIT:   chunk_limit_reg  <= pwdata[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_IDX_WORKERS: prdata = 32'(worker_count_reg);
            CFG_IDX_LIMIT:   prdata = 32'(chunk_limit_reg);
            default:         prdata = '0;
        endcase
    end

    wacd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    wacd_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_cmd            (s_cmd),
        .s_data_byte      (s_data_byte),
        .cfg_worker_count (worker_count_reg),
        .cfg_chunk_limit  (chunk_limit_reg),
        .dp_cmd           (dp_cmd),
        .dp_status        (dp_status),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_worker         (m_worker),
        .m_out_byte       (m_out_byte),
        .m_last           (m_last),
        .m_truncated      (m_truncated)
    );

endmodule

// ----- tb/sv/word_aligned_chunk_dispatcher_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for word_aligned_chunk_dispatcher: directed and random text
// streams, chunk traffic predicted in-bench and checked item by item on the m_ side.
// Depends on wacd_pkg and the word_aligned_chunk_dispatcher RTL.
module word_aligned_chunk_dispatcher_tb;
    import wacd_pkg::*;

    // longest quiet tail a correct block may still need after its last result
    localparam int SETTLE_CYCLES = 80;
    localparam int RUN_PHASES    = 6;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } text_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [WORKER_W-1:0] worker;
        logic [7:0]          out_byte;
        logic                last;
        logic                truncated;
    } chunk_result_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_cmd       = CMD_TEXT;
    logic [7:0]          s_data_byte = 8'h00;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [KIND_W-1:0]   m_kind;
    logic [WORKER_W-1:0] m_worker;
    logic [7:0]          m_out_byte;
    logic                m_last;
    logic                m_truncated;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = 3'd0;
    logic [31:0]         pwdata      = 32'd0;
    logic [31:0]         prdata;
    logic                pready;

    word_aligned_chunk_dispatcher u_top (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    text_item_t    text_feed [$];
    chunk_result_t dispatch_due [$];
    int unsigned   items_fed;
    int unsigned   results_seen;
    int unsigned   mismatches;
    bit            idle_on = 1'b1;
    bit            s_taken = 1'b0;
    int unsigned   in_gap;
    int unsigned   out_stall;

    // predicted dispatcher state and registers
    logic [7:0]          word_buf [MAX_WORD];
    int unsigned         word_len;
    int unsigned         fill_count;
    int unsigned         worker_ptr;
    bit                  word_cut;
    logic [WORKER_W-1:0] cfg_workers;
    logic [FILL_W-1:0]   cfg_limit;

    task automatic flag_mismatch(string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic bit is_delimiter(logic [7:0] b);
        return b == CH_SPACE || b == CH_NL || b == CH_TAB || b == CH_NUL;
    endfunction

    function automatic int unsigned active_workers();
        int unsigned c;
        c = cfg_workers;
        if (c == 0) c = 1;
        if (c > MAX_WORKERS) c = MAX_WORKERS;
        return c;
    endfunction

    function automatic int unsigned dest_worker();
        if (worker_ptr >= active_workers()) worker_ptr = 0;
        return worker_ptr + 1;
    endfunction

    function automatic void push_due(logic [KIND_W-1:0] kind, int unsigned worker,
                                     logic [7:0] b, bit cut);
        chunk_result_t r;
        r.kind      = kind;
        r.worker    = worker[WORKER_W-1:0];
        r.out_byte  = b;
        r.last      = 1'b0;
        r.truncated = cut;
        dispatch_due.push_back(r);
    endfunction

    function automatic void close_chunk();
        push_due(KIND_CHUNK_END, dest_worker(), 8'h00, 1'b0);
        worker_ptr++;
        if (worker_ptr >= active_workers()) worker_ptr = 0;
        fill_count = 0;
    endfunction

    function automatic void commit_word();
        int unsigned i;
        if (fill_count + word_len > cfg_limit) close_chunk();
        for (i = 0; i < word_len; i++)
            push_due(KIND_DATA, dest_worker(), word_buf[i], word_cut);
        fill_count = (fill_count + word_len) & 32'h7FF;
        word_len   = 0;
        word_cut   = 1'b0;
    endfunction

    // works out every result an accepted item causes, in order
    function automatic void dispatch_text_item(logic cmd, logic [7:0] b);
        int unsigned   base;
        int unsigned   w;
        chunk_result_t tail;
        base = dispatch_due.size();
        if (cmd == CMD_END) begin
            commit_word();
            close_chunk();
            for (w = 1; w <= active_workers(); w++)
                push_due(KIND_END_NOTICE, w, 8'h00, 1'b0);
            word_len   = 0;
            fill_count = 0;
            worker_ptr = 0;
            word_cut   = 1'b0;
        end else if (is_delimiter(b)) begin
            // NUL ends the word without being stored
            if (b != CH_NUL && word_len < MAX_WORD) begin
                word_buf[word_len] = b;
                word_len++;
            end
            commit_word();
        end else if (word_len + 1 < MAX_WORD) begin
            word_buf[word_len] = b;
            word_len++;
        end else begin
            word_cut = 1'b1;
        end
        if (dispatch_due.size() > base) begin
            tail      = dispatch_due.pop_back();
            tail.last = 1'b1;
            dispatch_due.push_back(tail);
        end
    endfunction

    function automatic string field_msg(string name, int got, int want);
        return $sformatf("result %0d: %s got %0d, want %0d", results_seen, name, got, want);
    endfunction

    task automatic check_result();
        chunk_result_t want;
        if (dispatch_due.size() == 0) begin
            flag_mismatch($sformatf("result %0d: kind %0d worker %0d with nothing due",
                                    results_seen, m_kind, m_worker));
        end else begin
            want = dispatch_due.pop_front();
            if (m_kind !== want.kind)
                flag_mismatch(field_msg("kind", m_kind, want.kind));
            if (m_worker !== want.worker)
                flag_mismatch(field_msg("worker", m_worker, want.worker));
            if (m_out_byte !== want.out_byte)
                flag_mismatch(field_msg("out_byte", m_out_byte, want.out_byte));
            if (m_last !== want.last)
                flag_mismatch(field_msg("last", m_last, want.last));
            if (m_truncated !== want.truncated)
                flag_mismatch(field_msg("truncated", m_truncated, want.truncated));
        end
        results_seen++;
    endtask

    // monitor: register writes, accepted inputs, accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == CFG_IDX_WORKERS) cfg_workers = pwdata[WORKER_W-1:0];
                else cfg_limit = pwdata[FILL_W-1:0];
            end
            if (s_valid && s_ready) dispatch_text_item(s_cmd, s_data_byte);
            if (m_valid && m_ready) check_result();
        end
        s_taken <= aresetn && s_valid && s_ready;
    end

    // input driver
    always @(negedge aclk) begin
        text_item_t it;
        if (!s_valid || s_taken) begin
            if (in_gap != 0 || text_feed.size() == 0) begin
                if (in_gap != 0) in_gap--;
                s_valid <= 1'b0;
            end else begin
                it = text_feed.pop_front();
                s_valid     <= 1'b1;
                s_cmd       <= it.cmd;
                s_data_byte <= it.data_byte;
                if (idle_on && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 12);
            end
        end
    end

    // result-side backpressure
    always @(negedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (out_stall != 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            out_stall = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic feed(logic cmd, logic [7:0] b);
        text_item_t it;
        it.cmd       = cmd;
        it.data_byte = b;
        text_feed.push_back(it);
        items_fed++;
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (is_delimiter(b));
        return b;
    endfunction

    function automatic logic [7:0] any_delimiter();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_NL;
            2: return CH_TAB;
            default: return CH_NUL;
        endcase
    endfunction

    task automatic feed_word(int unsigned len, logic [7:0] delim);
        int unsigned i;
        for (i = 0; i < len; i++) feed(CMD_TEXT, word_byte());
        feed(CMD_TEXT, delim);
    endtask

    // mostly whole words; some stray bytes, empty words and end-of-input
    task automatic feed_text_run(int unsigned n_items);
        int unsigned stop_at, pick, r, len;
        stop_at = items_fed + n_items;
        while (items_fed < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                r = $urandom_range(0, 19);
                if (r < 14) len = $urandom_range(1, 6);
                else if (r < 18) len = $urandom_range(7, 31);
                else len = $urandom_range(32, 44);
                feed_word(len, any_delimiter());
            end else if (pick < 88) begin
                feed(CMD_TEXT, 8'($urandom));
            end else if (pick < 94) begin
                feed(CMD_TEXT, CH_NUL);
            end else begin
                feed(CMD_END, 8'($urandom));
            end
        end
    endtask

    // write, then read back through the same port
    task automatic cfg_write(logic idx, logic [31:0] value);
        logic [31:0] want;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        want = (idx == CFG_IDX_WORKERS) ? 32'(cfg_workers) : 32'(cfg_limit);
        if (prdata !== want)
            flag_mismatch($sformatf("register %0d reads %0d, want %0d", idx, prdata, want));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender holds off until every due result is out and the block has gone quiet
    task automatic wait_drained();
        do @(posedge aclk);
        while (text_feed.size() != 0 || s_valid || dispatch_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned run_workers [RUN_PHASES];
        int unsigned run_limits [RUN_PHASES];
        int unsigned p;

        cfg_workers = WORKERS_RESET;
        cfg_limit   = LIMIT_RESET;
        word_len    = 0;
        fill_count  = 0;
        worker_ptr  = 0;
        word_cut    = 1'b0;
        run_workers = '{16, 3, 0, 31, 7, 1};
        run_limits  = '{1, 20, 0, 2047, 1024, 1};
        run_workers[RUN_PHASES-1] = $urandom_range(1, 16);
        run_limits[RUN_PHASES-1]  = $urandom_range(1, 200);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: delimiter kinds, empty words, back-to-back end of input
        feed_word(1, CH_SPACE);
        feed(CMD_TEXT, 8'hFF);
        feed(CMD_TEXT, CH_TAB);
        feed(CMD_TEXT, CH_NUL);
        feed_word(1, CH_NUL);
        feed(CMD_TEXT, CH_NL);
        feed(CMD_END, 8'hFF);
        feed(CMD_END, 8'h00);
        wait_drained();

        // small limit: flush on overflow, oversize word, empty word still flushing
        cfg_write(CFG_IDX_WORKERS, 32'd2);
        cfg_write(CFG_IDX_LIMIT, 32'd5);
        feed_word(2, CH_SPACE);
        feed_word(2, CH_SPACE);
        feed_word(6, CH_SPACE);
        feed(CMD_TEXT, CH_NUL);
        feed(CMD_END, 8'h5A);
        wait_drained();

        for (p = 0; p < RUN_PHASES; p++) begin
            if (p == RUN_PHASES - 1) idle_on = 1'b0;
            cfg_write(CFG_IDX_WORKERS, run_workers[p] | ($urandom & ~32'h1F));
            cfg_write(CFG_IDX_LIMIT, run_limits[p] | ($urandom & ~32'h7FF));
            if (p == 0) feed_word(40, CH_SPACE);
            feed_text_run(64);
            // first phase leaves its stream open so the next, smaller worker count
            // sees a stale pointer
            if (p != 0) feed(CMD_END, 8'($urandom));
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
